>>> hw/rtl/mcsma_pkg.sv
// ----------------------------------------------------------------------------
// mcsma_pkg
// Shared types and codes for the multichannel scan moving average core.
// ----------------------------------------------------------------------------
package mcsma_pkg;

    // Command codes of an input word
    localparam logic [1:0] CMD_SAMPLE  = 2'd0;
    localparam logic [1:0] CMD_READ    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    // Operation codes passed from front to back
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_STORE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Field widths fixed by the interface
    localparam int CMD_BITS    = 2;
    localparam int IN_SMP_BITS = 10;
    localparam int RD_CH_BITS  = 3;
    localparam int AVG_BITS    = 10;
    localparam int NXT_BITS    = 3;
    // Widest channel index and sample the core can be built for
    localparam int CH_MAX_BITS  = 4;
    localparam int SMP_MAX_BITS = 16;

    typedef struct packed {
        logic [CMD_BITS-1:0]    command;
        logic [IN_SMP_BITS-1:0] sample;
        logic [RD_CH_BITS-1:0]  read_channel;
    } in_word_t;

    typedef struct packed {
        logic [AVG_BITS-1:0] average;
        logic [NXT_BITS-1:0] next_channel;
    } out_word_t;

    // Classified operation handed to the back end
    typedef struct packed {
        logic [1:0]              kind;
        logic [CH_MAX_BITS-1:0]  chan;
        logic [SMP_MAX_BITS-1:0] sample;
        logic [NXT_BITS-1:0]     next_channel;
    } op_t;

endpackage

>>> hw/rtl/mcsma_fifo.sv
// ----------------------------------------------------------------------------
// mcsma_fifo
// Small synchronous FIFO; decouples the front end, back end and result port.
// ----------------------------------------------------------------------------
module mcsma_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    slot_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_wr, do_rd;

    assign full    = (count_reg == CNT_BITS'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage; no reset needed
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> hw/rtl/mcsma_front.sv
// ----------------------------------------------------------------------------
// mcsma_front
// Accepts input words, keeps the scan channel and classifies each command.
// ----------------------------------------------------------------------------
module mcsma_front #(
    parameter int CHANNELS = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mcsma_pkg::in_word_t in_word,
    output logic                full,
    output logic                op_valid,
    output mcsma_pkg::op_t      op,
    input  logic                op_full
);

    localparam int CH_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [CH_BITS-1:0] scan_reg, scan_next;
    logic               accept;
    logic               rd_ch_ok;

    assign full     = op_full;
    assign accept   = push && !op_full;
    assign op_valid = accept;
    assign rd_ch_ok = (5'(in_word.read_channel) < 5'(CHANNELS));

    // Classify the command and step the scan
    always_comb
    begin
        scan_next = scan_reg;
        op.kind   = mcsma_pkg::OP_NONE;
        op.chan   = mcsma_pkg::CH_MAX_BITS'(scan_reg);
        op.sample = mcsma_pkg::SMP_MAX_BITS'(in_word.sample);
        unique case (in_word.command)
            mcsma_pkg::CMD_SAMPLE:
            begin
                op.kind   = mcsma_pkg::OP_STORE;
                scan_next = (scan_reg == CH_BITS'(CHANNELS - 1)) ? '0 : scan_reg + 1'b1;
            end
            mcsma_pkg::CMD_READ:
            begin
                // A channel beyond the scan list reads as zero
                op.chan = mcsma_pkg::CH_MAX_BITS'(in_word.read_channel);
                op.kind = rd_ch_ok ? mcsma_pkg::OP_READ : mcsma_pkg::OP_NONE;
            end
            mcsma_pkg::CMD_RESTART:
            begin
                scan_next = '0;
            end
            default:
            begin
                op.kind = mcsma_pkg::OP_NONE;
            end
        endcase
        op.next_channel = mcsma_pkg::NXT_BITS'(scan_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= '0;
        end
        else if (accept)
        begin
            scan_reg <= scan_next;
        end
    end

endmodule

>>> hw/rtl/mcsma_back.sv
// ----------------------------------------------------------------------------
// mcsma_back
// Executes operations: sample store writes, window walk and mean scaling.
// ----------------------------------------------------------------------------
module mcsma_back #(
    parameter int CHANNELS    = 6,
    parameter int WINDOW      = 8,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 op_empty,
    input  mcsma_pkg::op_t       op,
    output logic                 op_pop,
    output logic                 res_push,
    output mcsma_pkg::out_word_t res,
    input  logic                 res_full
);

    localparam int CH_BITS   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int POS_BITS  = $clog2(WINDOW);
    localparam int ENTRIES   = CHANNELS * WINDOW;
    localparam int ADDR_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SUM_BITS  = SAMPLE_BITS + $clog2(WINDOW);
    // Division by WINDOW as a multiply by a rounded-up reciprocal; exact for
    // every sum below 2**SUM_BITS
    localparam int DIV_SHIFT = SUM_BITS + $clog2(WINDOW);
    localparam int MUL_BITS  = SUM_BITS + 1;
    localparam int PROD_BITS = SUM_BITS + MUL_BITS;
    localparam logic [MUL_BITS-1:0] DIV_MUL =
        MUL_BITS'((2 ** DIV_SHIFT + WINDOW - 1) / WINDOW);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WALK = 3'd1;
    localparam logic [2:0] S_TAIL = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [SAMPLE_BITS-1:0] mem [ENTRIES];
    logic [ENTRIES-1:0]     valid_reg, valid_next;
    logic [POS_BITS-1:0]    ring_reg [CHANNELS];
    logic [POS_BITS-1:0]    ring_next [CHANNELS];

    logic [ADDR_BITS-1:0]   base_reg, base_next;
    logic [POS_BITS-1:0]    idx_reg, idx_next;
    logic [SUM_BITS-1:0]    sum_reg, sum_next;
    logic [SUM_BITS-1:0]    total_reg, total_next;
    logic                   pend_reg, pend_next;
    logic [mcsma_pkg::NXT_BITS-1:0] nxt_reg, nxt_next;
    logic [mcsma_pkg::AVG_BITS-1:0] avg_reg, avg_next;

    logic [ADDR_BITS-1:0]   rd_addr;
    logic [SAMPLE_BITS-1:0] rd_data_reg;
    logic                   rd_hit_reg;
    logic [SAMPLE_BITS-1:0] rd_val;
    logic [ADDR_BITS-1:0]   wr_addr;
    logic                   wr_en;
    logic [CH_BITS-1:0]     op_ch;
    logic [POS_BITS-1:0]    op_pos;
    logic [ADDR_BITS-1:0]   op_base;
    logic [PROD_BITS-1:0]   prod;

    assign op_ch   = CH_BITS'(op.chan);
    assign op_pos  = ring_reg[op_ch];
    assign op_base = ADDR_BITS'(op_ch) * ADDR_BITS'(WINDOW);
    assign wr_addr = op_base + ADDR_BITS'(op_pos);
    assign wr_en   = (state_reg == S_IDLE) && !op_empty && (op.kind == mcsma_pkg::OP_STORE);
    assign rd_addr = base_reg + ADDR_BITS'(idx_reg);
    assign rd_val  = rd_hit_reg ? rd_data_reg : '0;
    assign prod    = PROD_BITS'(total_reg) * PROD_BITS'(DIV_MUL);

    assign op_pop   = (state_reg == S_IDLE) && !op_empty;
    assign res_push = (state_reg == S_OUT) && !res_full;
    assign res.average      = avg_reg;
    assign res.next_channel = nxt_reg;

    // Sequencer: store, window walk, reciprocal scaling, result hand-off
    always_comb
    begin
        state_next = state_reg;
        valid_next = valid_reg;
        ring_next  = ring_reg;
        base_next  = base_reg;
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        total_next = total_reg;
        pend_next  = 1'b0;
        nxt_next   = nxt_reg;
        avg_next   = avg_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!op_empty)
                begin
                    nxt_next = op.next_channel;
                    avg_next = '0;
                    unique case (op.kind)
                        mcsma_pkg::OP_STORE:
                        begin
                            valid_next[wr_addr] = 1'b1;
                            ring_next[op_ch] = (op_pos == POS_BITS'(WINDOW - 1)) ?
                                               '0 : op_pos + 1'b1;
                            state_next = S_OUT;
                        end
                        mcsma_pkg::OP_READ:
                        begin
                            base_next  = op_base;
                            idx_next   = '0;
                            sum_next   = '0;
                            state_next = S_WALK;
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                // One read per cycle; data of the previous address lands now
                pend_next = 1'b1;
                if (pend_reg)
                begin
                    sum_next = sum_reg + SUM_BITS'(rd_val);
                end
                if (idx_reg == POS_BITS'(WINDOW - 1))
                begin
                    state_next = S_TAIL;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_TAIL:
            begin
                total_next = sum_reg + SUM_BITS'(rd_val);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                // Truncated mean from the registered window total
                avg_next   = mcsma_pkg::AVG_BITS'(prod >> DIV_SHIFT);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!res_full)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            pend_reg  <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                ring_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
            ring_reg  <= ring_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        base_reg  <= base_next;
        idx_reg   <= idx_next;
        sum_reg   <= sum_next;
        total_reg <= total_next;
        nxt_reg   <= nxt_next;
        avg_reg   <= avg_next;
    end

    // Sample memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= SAMPLE_BITS'(op.sample);
        end
        rd_data_reg <= mem[rd_addr];
        rd_hit_reg  <= valid_reg[rd_addr];
    end

endmodule

>>> hw/rtl/multichannel_scan_moving_average_core.sv
// ----------------------------------------------------------------------------
// multichannel_scan_moving_average_core
// Round-robin converter scanner with a per-channel moving average.
// ----------------------------------------------------------------------------
// Every accepted word yields one result word carrying the channel selected for
// the next conversion; a read of a scanned channel also carries the truncated
// mean of its last WINDOW samples, anything else carries an average of 0.
// Words are executed one at a time by the back end: a sample or restart is
// taken and its result handed off; a read, paced by the single read port of
// the sample memory, takes the word, makes WINDOW reads, adds the last
// sample, applies the reciprocal multiply that divides by WINDOW and hands
// off the result. The hand-off waits while the result queue is full.
// Two-entry queues sit between front and back and in front of the result
// port, so input and output stall independently.
// The sample memory reads as zero from reset through per-entry valid bits; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module multichannel_scan_moving_average_core #(
    parameter int CHANNELS    = 6,
    parameter int WINDOW      = 8,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  mcsma_pkg::in_word_t  in_word,
    output logic                 empty,
    input  logic                 pop,
    output mcsma_pkg::out_word_t out_word
);

    logic                 op_push;
    mcsma_pkg::op_t       op_in;
    logic                 op_full;
    logic                 op_pop;
    mcsma_pkg::op_t       op_out;
    logic                 op_empty;
    logic                 res_push;
    mcsma_pkg::out_word_t res;
    logic                 res_full;

    mcsma_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .in_word  (in_word),
        .full     (full),
        .op_valid (op_push),
        .op       (op_in),
        .op_full  (op_full)
    );

    mcsma_fifo #(
        .WIDTH ($bits(mcsma_pkg::op_t)),
        .DEPTH (2)
    ) u_op_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (op_push),
        .wr_data (op_in),
        .full    (op_full),
        .rd_en   (op_pop),
        .rd_data (op_out),
        .empty   (op_empty)
    );

    mcsma_back #(
        .CHANNELS    (CHANNELS),
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_empty (op_empty),
        .op       (op_out),
        .op_pop   (op_pop),
        .res_push (res_push),
        .res      (res),
        .res_full (res_full)
    );

    mcsma_fifo #(
        .WIDTH ($bits(mcsma_pkg::out_word_t)),
        .DEPTH (2)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (out_word),
        .empty   (empty)
    );

endmodule
